[rtl/core/complex_phase_angle_assert.svh]
// complex_phase_angle_assert.svh: assertion macros for the phase angle block
// expects signals named clk and arst_n in the scope of use
`ifndef COMPLEX_PHASE_ANGLE_ASSERT_SVH
`define COMPLEX_PHASE_ANGLE_ASSERT_SVH

// same-cycle implication, off during reset
`define CPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/cpa_pkg.sv]
// cpa_pkg.sv: shared types, constants and the step angle table for the phase angle block
// no dependencies
`timescale 1ns / 1ps

package cpa_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int TURN_LOG2       = 40;
	localparam int GUARD_SHIFT     = 20;
	localparam int GROW_BITS       = 3;
	localparam int STEP_EXTRA      = 6;
	localparam int ZW              = TURN_LOG2 + 2;

	localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(1) << (TURN_LOG2 - 2);
	localparam logic signed [ZW-1:0] Z_HALF    = ZW'(1) << (TURN_LOG2 - 1);

	typedef struct packed {
		logic valid;
		logic last;
		logic bypass;
	} ctl_t;

	// 2^m / d by shift and subtract, elaboration only
	function automatic logic [63:0] pow2_div(int unsigned m, logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] num;
		logic [63:0] q;
		num = 64'd1 << m;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-k) with a full turn = 2^TURN_LOG2, from the arctangent series
	function automatic logic signed [ZW-1:0] step_angle(int unsigned k);
		logic [63:0]  rad;
		logic [63:0]  term;
		logic [127:0] prod;
		logic [63:0]  hi;
		int unsigned  n;
		rad = '0;
		n   = 0;
		if (k == 0) begin
			return ZW'(64'd1 << (TURN_LOG2 - 3));
		end
		while (k * (2 * n + 1) <= 62) begin
			term = pow2_div(62 - k * (2 * n + 1), 64'(2 * n + 1));
			if (n[0]) begin
				rad = rad - term;
			end else begin
				rad = rad + term;
			end
			n++;
		end
		prod = {64'd0, rad} * {64'd0, INV_PI_Q64};
		hi   = prod[127:64];
		return ZW'((hi + (64'd1 << 22)) >> 23);
	endfunction

endpackage

[rtl/core/cpa_prerot.sv]
// cpa_prerot.sv: input cell, axis cases and quarter-turn fold into the right half plane
// depends on cpa_pkg
`timescale 1ns / 1ps

module cpa_prerot #(
	parameter int SAMPLE_BITS = cpa_pkg::SAMPLE_BITS_DEF,
	parameter int XW          = SAMPLE_BITS + 1 + cpa_pkg::GUARD_SHIFT + cpa_pkg::GROW_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [SAMPLE_BITS-1:0]       sample_real,
	input  logic signed [SAMPLE_BITS-1:0]       sample_imag,
	input  logic                                in_last,
	input  logic                                dn_take,
	output logic                                up_take,
	output cpa_pkg::ctl_t                       ctl_s1,
	output logic signed [XW-1:0]                x_s1,
	output logic signed [XW-1:0]                y_s1,
	output logic signed [cpa_pkg::ZW-1:0]       z_s1
);

	localparam int PAD = XW - SAMPLE_BITS - 1 - cpa_pkg::GUARD_SHIFT;

	logic signed [SAMPLE_BITS:0]    xe, ye, xr, yr;
	logic signed [cpa_pkg::ZW-1:0]  z_nxt;
	logic                           byp_nxt;

	always_comb begin
		xe      = {sample_real[SAMPLE_BITS-1], sample_real};
		ye      = {sample_imag[SAMPLE_BITS-1], sample_imag};
		xr      = xe;
		yr      = ye;
		z_nxt   = '0;
		byp_nxt = 1'b0;
		priority if (ye == '0) begin
			byp_nxt = 1'b1;
			z_nxt   = xe[SAMPLE_BITS] ? -cpa_pkg::Z_HALF : '0;
		end else if (xe == '0) begin
			byp_nxt = 1'b1;
			z_nxt   = ye[SAMPLE_BITS] ? -cpa_pkg::Z_QUARTER : cpa_pkg::Z_QUARTER;
		end else if (xe[SAMPLE_BITS]) begin
			if (!ye[SAMPLE_BITS]) begin
				xr    = ye;
				yr    = -xe;
				z_nxt = cpa_pkg::Z_QUARTER;
			end else begin
				xr    = -ye;
				yr    = xe;
				z_nxt = -cpa_pkg::Z_QUARTER;
			end
		end else begin
			// right half plane goes in as it is
			xr    = xe;
			yr    = ye;
			z_nxt = '0;
		end
	end

	assign up_take = !ctl_s1.valid || dn_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (up_take) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.last   <= in_last;
			ctl_s1.bypass <= byp_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (up_take) begin
			x_s1 <= {{PAD{xr[SAMPLE_BITS]}}, xr, {cpa_pkg::GUARD_SHIFT{1'b0}}};
			y_s1 <= {{PAD{yr[SAMPLE_BITS]}}, yr, {cpa_pkg::GUARD_SHIFT{1'b0}}};
			z_s1 <= z_nxt;
		end
	end

endmodule

[rtl/core/cpa_cell.sv]
// cpa_cell.sv: one vectoring micro-rotation cell of the chain
// depends on cpa_pkg
`timescale 1ns / 1ps

module cpa_cell #(
	parameter int          XW   = 40,
	parameter int unsigned STEP = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpa_pkg::ctl_t                  up_ctl,
	input  logic signed [XW-1:0]           x_in,
	input  logic signed [XW-1:0]           y_in,
	input  logic signed [cpa_pkg::ZW-1:0]  z_in,
	input  logic                           dn_take,
	output logic                           up_take,
	output cpa_pkg::ctl_t                  ctl_s1,
	output logic signed [XW-1:0]           x_s1,
	output logic signed [XW-1:0]           y_s1,
	output logic signed [cpa_pkg::ZW-1:0]  z_s1
);

	localparam logic signed [cpa_pkg::ZW-1:0] ANGLE = cpa_pkg::step_angle(STEP);

	logic signed [XW-1:0]          xs, ys, x_nxt, y_nxt;
	logic signed [cpa_pkg::ZW-1:0] z_nxt;

	always_comb begin
		xs = x_in >>> STEP;
		ys = y_in >>> STEP;
		if (!y_in[XW-1]) begin
			x_nxt = x_in + ys;
			y_nxt = y_in - xs;
			z_nxt = z_in + ANGLE;
		end else begin
			x_nxt = x_in - ys;
			y_nxt = y_in + xs;
			z_nxt = z_in - ANGLE;
		end
		// axis cases carry their final angle untouched
		if (up_ctl.bypass) begin
			z_nxt = z_in;
		end
	end

	assign up_take = !ctl_s1.valid || dn_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (up_take) begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (up_take) begin
			x_s1 <= x_nxt;
			y_s1 <= y_nxt;
			z_s1 <= z_nxt;
		end
	end

endmodule

[rtl/core/cpa_round.sv]
// cpa_round.sv: output cell, rounds the angle to the port width and holds the request
// depends on cpa_pkg
`timescale 1ns / 1ps

module cpa_round #(
	parameter int ANGLE_BITS = cpa_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpa_pkg::ctl_t                  up_ctl,
	input  logic signed [cpa_pkg::ZW-1:0]  z_in,
	input  logic                           out_stall,
	output logic                           up_take,
	output logic                           out_valid,
	output logic signed [ANGLE_BITS-1:0]   phase,
	output logic                           out_last
);

	localparam int DROP = cpa_pkg::TURN_LOG2 - ANGLE_BITS;

	logic [cpa_pkg::ZW-1:0] z_rnd;
	logic                   valid_q;
	logic [ANGLE_BITS-1:0]  phase_q;
	logic                   last_q;

	// round half up, then keep the top bits of the turn (wraps +pi to -pi)
	assign z_rnd   = z_in + (cpa_pkg::ZW'(1) << (DROP - 1));
	assign up_take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_take) begin
			valid_q <= up_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_take) begin
			phase_q <= z_rnd[DROP +: ANGLE_BITS];
			last_q  <= up_ctl.last;
		end
	end

	assign out_valid = valid_q;
	assign phase     = $signed(phase_q);
	assign out_last  = last_q;

endmodule

[rtl/core/complex_phase_angle.sv]
// complex_phase_angle.sv: top level, four-quadrant phase angle of a complex sample stream
// depends on cpa_pkg, cpa_prerot, cpa_cell, cpa_round
`timescale 1ns / 1ps
// usage
// - input request: sample_real, sample_imag (signed) and in_last, taken on a rising
//   edge where in_valid is high and in_stall is low
// - output request: phase (signed, 2^(ANGLE_BITS-1) is pi, +pi shows as the most
//   negative code) and out_last, taken where out_valid is high and out_stall is low
// - throughput: one sample per cycle while out_stall is low, through a chain of ANGLE_BITS+6
//   rotation cells, each doing one shift-add step and handing its x, y, z to the next cell
//   whenever that cell takes; from acceptance to out_valid a request passes ANGLE_BITS+8
//   registers in a row (one input cell, the rotation cells and one output rounding
//   register), the first loaded at the accepting edge
// - each cell moves when it is empty or its neighbor takes, so empty slots collapse;
//   with out_stall high the chain keeps filling and in_stall rises only once
//   every cell holds a request
// - a stalled result holds its value on the ports until taken
// - reset clears every valid bit; data registers are not reset, nothing to load after reset
// - zero sample and axis points are resolved in the input cell and ride the chain
//   with their exact angle

module complex_phase_angle #(
	parameter int SAMPLE_BITS = cpa_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_BITS  = cpa_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_real,
	input  logic signed [SAMPLE_BITS-1:0] sample_imag,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ANGLE_BITS-1:0]  phase,
	output logic                          out_last
);

	// x/y width: sign + sample + guard bits + headroom for the cordic gain
	localparam int XW    = SAMPLE_BITS + 1 + cpa_pkg::GUARD_SHIFT + cpa_pkg::GROW_BITS;
	localparam int STEPS = ANGLE_BITS + cpa_pkg::STEP_EXTRA;

	// index 0 is the input cell, 1..STEPS the rotation cells
	cpa_pkg::ctl_t                 ctl_c [0:STEPS];
	logic signed [XW-1:0]          x_c   [0:STEPS];
	logic signed [XW-1:0]          y_c   [0:STEPS];
	logic signed [cpa_pkg::ZW-1:0] z_c   [0:STEPS];
	// take_c[i]: cell i loads this cycle; STEPS+1 is the output cell
	logic                          take_c [0:STEPS+1];

	cpa_prerot #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.XW          (XW)
	) u_prerot (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.in_last     (in_last),
		.dn_take     (take_c[1]),
		.up_take     (take_c[0]),
		.ctl_s1      (ctl_c[0]),
		.x_s1        (x_c[0]),
		.y_s1        (y_c[0]),
		.z_s1        (z_c[0])
	);

	assign in_stall = !take_c[0];

	// rotation chain, cell i does step i-1
	for (genvar i = 1; i <= STEPS; i++) begin : g_cell
		cpa_cell #(
			.XW   (XW),
			.STEP (i - 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_ctl  (ctl_c[i-1]),
			.x_in    (x_c[i-1]),
			.y_in    (y_c[i-1]),
			.z_in    (z_c[i-1]),
			.dn_take (take_c[i+1]),
			.up_take (take_c[i]),
			.ctl_s1  (ctl_c[i]),
			.x_s1    (x_c[i]),
			.y_s1    (y_c[i]),
			.z_s1    (z_c[i])
		);
	end

	cpa_round #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_ctl    (ctl_c[STEPS]),
		.z_in      (z_c[STEPS]),
		.out_stall (out_stall),
		.up_take   (take_c[STEPS+1]),
		.out_valid (out_valid),
		.phase     (phase),
		.out_last  (out_last)
	);

endmodule

[rtl/core/cpa_checker.sv]
// cpa_checker.sv: port-level checks for complex_phase_angle, bound to the top level
// depends on cpa_pkg and complex_phase_angle_assert.svh
`timescale 1ns / 1ps
`include "complex_phase_angle_assert.svh"

module cpa_checker #(
	parameter int SAMPLE_BITS = cpa_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_BITS  = cpa_pkg::ANGLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_real,
	input logic signed [SAMPLE_BITS-1:0] sample_imag,
	input logic                          in_last,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [ANGLE_BITS-1:0]  phase,
	input logic                          out_last
);

	// input cell + rotation cells + output register
	localparam int DEPTH = ANGLE_BITS + cpa_pkg::STEP_EXTRA + 2;
	localparam int CW    = $clog2(DEPTH + 2);

	logic          in_acc, out_acc;
	logic [CW-1:0] inflight_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	`CPA_ASSERT_NOW(a_no_invented, out_valid, inflight_q != '0, "result with no request in flight")
	`CPA_ASSERT_NOW(a_depth, 1'b1, inflight_q <= CW'(DEPTH), "more requests in flight than cells")
	`CPA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while output drains")
	`CPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(phase) && $stable(out_last), "stalled result changed")
	`CPA_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(sample_real) && $stable(sample_imag) && $stable(in_last),
		"stalled request changed")

endmodule

bind complex_phase_angle cpa_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.ANGLE_BITS  (ANGLE_BITS)
) u_cpa_checker (.*);
